// File: design/tcsp_pkg.sv
// shared types and constants for the two-choice slot placement block
package tcsp_pkg;

  localparam int unsigned SLOT_W        = 10;
  localparam int unsigned SLOTS_DEFAULT = 1024;

  typedef struct packed {
    logic              taken;
    logic [SLOT_W-1:0] alt;
  } slot_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_LO,
    ST_CHECK_LO,
    ST_CHECK_HI,
    ST_START,
    ST_WALK,
    ST_SHIFT,
    ST_FINISH
  } state_t;

endpackage

// File: design/two_choice_slot_placement_core.sv
// top level of the two-choice slot placement block
//
// input channel: in_valid/in_ready carry slot_a and slot_b, two candidate
// slots for a new item. output channel: out_valid/out_ready carry placed,
// one beat per input beat, 1 when the item was stored, 0 when rejected.
// one item is in work at a time; in_ready is high only while idle.
// the result is found with one read of the lower slot when it is free, and
// a read of the higher slot as well when only the higher one is; each
// displacement hop takes one read of the slot memory port, first for the walk
// and again for the shift, and each walk start adds a step of its own.
// the next input beat can be taken in the cycle after the result is loaded.
// after reset a clearing pass writes every slot free, one entry a cycle;
// no input beat is taken during it.
// the result sits in an output register; a finished item waits there while
// out_ready is low and the next item is taken once the sequencer is idle,
// so a stalled receiver blocks the block only after one more item.
module two_choice_slot_placement_core #(
  parameter int unsigned SLOTS = tcsp_pkg::SLOTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcsp_pkg::SLOT_W-1:0] slot_a,
  input  logic [tcsp_pkg::SLOT_W-1:0] slot_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        placed
);
  import tcsp_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  slot_entry_t   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_entry_t   wr_data;
  logic          res_load;
  logic          res_bit;
  logic          res_free;

  tcsp_ctrl #(
    .SLOTS(SLOTS),
    .AW   (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .slot_a  (slot_a),
    .slot_b  (slot_b),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res_load(res_load),
    .res_bit (res_bit),
    .res_free(res_free)
  );

  tcsp_slot_mem #(
    .SLOTS(SLOTS),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  tcsp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .load_bit (res_bit),
    .free     (res_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .placed   (placed)
  );

endmodule

// File: design/tcsp_slot_mem.sv
// slot store: taken flag and alternate slot per entry, one read and one write port
module tcsp_slot_mem #(
  parameter int unsigned SLOTS = tcsp_pkg::SLOTS_DEFAULT,
  parameter int unsigned AW    = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output tcsp_pkg::slot_entry_t rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  tcsp_pkg::slot_entry_t wr_data
);
  import tcsp_pkg::*;

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/tcsp_out_reg.sv
// result output register with valid/ready handshake
module tcsp_out_reg (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic load_bit,
  output logic free,
  output logic out_valid,
  input  logic out_ready,
  output logic placed
);
  import tcsp_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      placed <= load_bit;
    end
  end

endmodule

// File: design/tcsp_ctrl.sv
// placement sequencer: lookups, displacement walk and chain shift over the slot store
module tcsp_ctrl #(
  parameter int unsigned SLOTS = tcsp_pkg::SLOTS_DEFAULT,
  parameter int unsigned AW    = $clog2(SLOTS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcsp_pkg::SLOT_W-1:0]   slot_a,
  input  logic [tcsp_pkg::SLOT_W-1:0]   slot_b,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  tcsp_pkg::slot_entry_t         rd_data,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output tcsp_pkg::slot_entry_t         wr_data,
  output logic                          res_load,
  output logic                          res_bit,
  input  logic                          res_free
);
  import tcsp_pkg::*;

  state_t            state, state_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;
  logic [SLOT_W-1:0] lo, lo_next;
  logic [SLOT_W-1:0] hi, hi_next;
  logic [SLOT_W-1:0] lo_alt, lo_alt_next;
  logic [SLOT_W-1:0] hi_alt, hi_alt_next;
  logic [SLOT_W-1:0] nxt, nxt_next;
  logic              from_hi, from_hi_next;
  logic              res, res_next;
  logic [SLOT_W-1:0] start_c;
  logic [SLOT_W-1:0] start_n;

  function automatic logic in_range(input logic [SLOT_W-1:0] x);
    return 32'(x) < SLOTS;
  endfunction

  assign start_c = from_hi ? hi : lo;
  assign start_n = from_hi ? hi_alt : lo_alt;
  assign res_bit = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      from_hi  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      from_hi  <= from_hi_next;
    end
  end

  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    lo_alt <= lo_alt_next;
    hi_alt <= hi_alt_next;
    nxt    <= nxt_next;
    res    <= res_next;
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    lo_next       = lo;
    hi_next       = hi;
    lo_alt_next   = lo_alt;
    hi_alt_next   = hi_alt;
    nxt_next      = nxt;
    from_hi_next  = from_hi;
    res_next      = res;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    res_load      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          lo_next    = (slot_a < slot_b) ? slot_a : slot_b;
          hi_next    = (slot_a < slot_b) ? slot_b : slot_a;
          state_next = ST_READ_LO;
        end
      end
      ST_READ_LO: begin
        if (!in_range(hi)) begin
          res_next   = 1'b0;
          state_next = ST_FINISH;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(lo);
          state_next = ST_CHECK_LO;
        end
      end
      ST_CHECK_LO: begin
        lo_alt_next = rd_data.alt;
        if (!rd_data.taken) begin
          wr_en      = 1'b1;
          wr_addr    = AW'(lo);
          wr_data    = '{taken: 1'b1, alt: hi};
          res_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(hi);
          state_next = ST_CHECK_HI;
        end
      end
      ST_CHECK_HI: begin
        hi_alt_next = rd_data.alt;
        if (!rd_data.taken) begin
          wr_en      = 1'b1;
          wr_addr    = AW'(hi);
          wr_data    = '{taken: 1'b1, alt: hi};
          res_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          from_hi_next = 1'b0;
          state_next   = ST_START;
        end
      end
      ST_START: begin
        // first hop of a walk from the lower, then the higher slot
        if (start_n == start_c || !in_range(start_n)) begin
          if (from_hi) begin
            res_next   = 1'b0;
            state_next = ST_FINISH;
          end else begin
            from_hi_next = 1'b1;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(start_n);
          nxt_next   = start_n;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!rd_data.taken) begin
          // chain ends in a free slot: new item takes the start slot
          wr_en      = 1'b1;
          wr_addr    = AW'(start_c);
          wr_data    = '{taken: 1'b1, alt: hi};
          rd_en      = 1'b1;
          rd_addr    = AW'(start_n);
          nxt_next   = start_n;
          state_next = ST_SHIFT;
        end else if (rd_data.alt == nxt || !in_range(rd_data.alt)) begin
          if (from_hi) begin
            res_next   = 1'b0;
            state_next = ST_FINISH;
          end else begin
            from_hi_next = 1'b1;
            state_next   = ST_START;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = AW'(rd_data.alt);
          nxt_next = rd_data.alt;
        end
      end
      ST_SHIFT: begin
        // every moved occupant lands in its own higher slot
        wr_en   = 1'b1;
        wr_addr = AW'(nxt);
        wr_data = '{taken: 1'b1, alt: nxt};
        if (!rd_data.taken) begin
          res_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = AW'(rd_data.alt);
          nxt_next = rd_data.alt;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sim/tb.sv
// self-checking testbench for two_choice_slot_placement_core: slot-store predictor, random stalls
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcsp_pkg::*;

  localparam int unsigned NSLOTS       = SLOTS_DEFAULT;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 40;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct {
    slot_idx_t   a;
    slot_idx_t   b;
    int unsigned gap;
    bit          drain;
  } offer_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  slot_idx_t slot_a    = '0;
  slot_idx_t slot_b    = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      placed;

  two_choice_slot_placement_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .slot_a    (slot_a),
    .slot_b    (slot_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .placed    (placed)
  );

  always #4 clk = ~clk;

  // predicted slot store
  bit        slot_full [NSLOTS];
  slot_idx_t slot_alt  [NSLOTS];

  offer_t      offers[$];
  bit          placed_due[$];
  int unsigned mismatches = 0;
  int unsigned accepted   = 0;
  int unsigned checked    = 0;
  int unsigned n_placed   = 0;
  int unsigned n_shifted  = 0;
  int unsigned cycles     = 0;
  int unsigned send_wait  = 0;
  int unsigned recv_wait  = 0;
  int unsigned hold_left  = 0;
  bit          hold_fired = 1'b0;
  bit          due_bit;
  bit          want;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // walk from a taken slot; true when the chain ends in a free slot
  function automatic bit chain_frees(input int unsigned start);
    int unsigned cur;
    int unsigned nxt;
    cur = start;
    for (int unsigned n = 0; n < NSLOTS; n++) begin
      nxt = 32'(slot_alt[slot_idx_t'(cur)]);
      if (nxt == cur || nxt >= NSLOTS) return 1'b0;
      if (!slot_full[slot_idx_t'(nxt)]) return 1'b1;
      cur = nxt;
    end
    return 1'b0;
  endfunction

  // each occupant on the chain moves to its higher slot, new item takes start
  function automatic void chain_move(input int unsigned start, input int unsigned carry_in);
    int unsigned cur;
    int unsigned carry;
    int unsigned moved;
    cur   = start;
    carry = carry_in;
    for (int unsigned n = 0; n < NSLOTS; n++) begin
      moved                     = 32'(slot_alt[slot_idx_t'(cur)]);
      slot_alt[slot_idx_t'(cur)] = slot_idx_t'(carry);
      if (moved >= NSLOTS) return;
      if (!slot_full[slot_idx_t'(moved)]) begin
        slot_full[slot_idx_t'(moved)] = 1'b1;
        slot_alt[slot_idx_t'(moved)]  = slot_idx_t'(moved);
        return;
      end
      carry = moved;
      cur   = moved;
    end
  endfunction

  function automatic bit placement_outcome(input slot_idx_t a, input slot_idx_t b);
    int unsigned lo;
    int unsigned hi;
    lo = (a < b) ? 32'(a) : 32'(b);
    hi = (a < b) ? 32'(b) : 32'(a);
    if (hi >= NSLOTS) return 1'b0;
    if (!slot_full[slot_idx_t'(lo)]) begin
      slot_full[slot_idx_t'(lo)] = 1'b1;
      slot_alt[slot_idx_t'(lo)]  = slot_idx_t'(hi);
      return 1'b1;
    end
    if (!slot_full[slot_idx_t'(hi)]) begin
      slot_full[slot_idx_t'(hi)] = 1'b1;
      slot_alt[slot_idx_t'(hi)]  = slot_idx_t'(hi);
      return 1'b1;
    end
    if (chain_frees(lo)) begin
      chain_move(lo, hi);
      n_shifted++;
      return 1'b1;
    end
    if (chain_frees(hi)) begin
      chain_move(hi, hi);
      n_shifted++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic add_offer(input int unsigned a, input int unsigned b,
                           input int unsigned gap, input bit drain);
    offer_t o;
    o.a     = slot_idx_t'(a);
    o.b     = slot_idx_t'(b);
    o.gap   = gap;
    o.drain = drain;
    offers.push_back(o);
  endtask

  // input side: predict on every accepted beat, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        due_bit = placement_outcome(slot_a, slot_b);
        placed_due.push_back(due_bit);
        accepted++;
        if (due_bit) n_placed++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (offers.size() != 0 && !(offers[0].drain && placed_due.size() != 0)) begin
          in_valid  <= 1'b1;
          slot_a    <= offers[0].a;
          slot_b    <= offers[0].b;
          send_wait = offers[0].gap;
          void'(offers.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (placed_due.size() == 0) begin
          flag_mismatch("result beat with no item outstanding");
        end else begin
          want = placed_due.pop_front();
          if (placed !== want)
            flag_mismatch($sformatf("result %0d: placed %b, want %b", checked, placed, want));
        end
        checked++;
        // a quarter of every hundred results goes without stalls
        recv_wait = (checked % 100 < 25) ? 0 : $urandom_range(0, 11);
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_fired && accepted >= HOLD_AT) begin
      hold_left  <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, placed_due.size());
      $display("two_choice_slot_placement_core regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned width;
    int unsigned base;
    int unsigned burst;
    int unsigned total;
    int unsigned gap;
    bit          calm;
    bit          drain;

    for (int unsigned s = 0; s < NSLOTS; s++) begin
      slot_full[slot_idx_t'(s)] = 1'b0;
      slot_alt[slot_idx_t'(s)]  = '0;
    end

    // directed: equal and swapped candidates, both ends, chain hits and misses
    add_offer(0, 0, $urandom_range(0, 3), 1'b0);
    add_offer(0, 0, $urandom_range(0, 3), 1'b0);
    add_offer(1023, 1023, $urandom_range(0, 3), 1'b0);
    add_offer(1023, 0, $urandom_range(0, 3), 1'b0);
    add_offer(0, 1023, $urandom_range(0, 3), 1'b0);
    add_offer(5, 3, $urandom_range(0, 3), 1'b0);
    add_offer(3, 7, $urandom_range(0, 3), 1'b0);
    add_offer(10, 11, $urandom_range(0, 3), 1'b0);
    add_offer(11, 13, $urandom_range(0, 3), 1'b0);
    add_offer(11, 10, $urandom_range(0, 3), 1'b0);
    add_offer(10, 11, $urandom_range(0, 3), 1'b0);
    add_offer(30, 30, $urandom_range(0, 3), 1'b0);
    add_offer(40, 41, $urandom_range(0, 3), 1'b0);
    add_offer(30, 40, $urandom_range(0, 3), 1'b0);
    add_offer(682, 341, $urandom_range(0, 3), 1'b0);
    add_offer(341, 682, $urandom_range(0, 3), 1'b0);
    add_offer(341, 682, $urandom_range(0, 3), 1'b0);
    add_offer(100, 101, 0, 1'b0);
    add_offer(101, 102, 0, 1'b0);
    add_offer(102, 103, 0, 1'b0);
    add_offer(103, 104, 0, 1'b0);
    add_offer(100, 101, $urandom_range(0, 3), 1'b0);
    add_offer(512, 511, $urandom_range(0, 3), 1'b0);

    // random: bursts inside one window so chains form, with some noise
    total = offers.size();
    while (total < offers.size() + RANDOM_ITEMS && offers.size() < 23 + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: width = 4;
        3, 4, 5: width = 16;
        6, 7:    width = 64;
        8:       width = 256;
        default: width = 1024;
      endcase
      base  = $urandom_range(0, NSLOTS - width);
      burst = $urandom_range(4, 30);
      calm  = ($urandom_range(0, 3) == 0);
      // sender pauses until every result is in, never near the hold-off
      drain = (offers.size() == 23) ||
              ($urandom_range(0, 7) == 0 &&
               (offers.size() + 40 < HOLD_AT || offers.size() > HOLD_AT + 60));
      for (int unsigned k = 0; k < burst; k++) begin
        gap = calm ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 9) == 0)
          add_offer($urandom_range(0, NSLOTS - 1), $urandom_range(0, NSLOTS - 1), gap,
                    drain && k == 0);
        else
          add_offer(base + $urandom_range(0, width - 1), base + $urandom_range(0, width - 1),
                    gap, drain && k == 0);
      end
      total = offers.size();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (offers.size() != 0 || in_valid) @(posedge clk);
    while (placed_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d placed (%0d through a displacement chain), %0d rejected",
             accepted, n_placed, n_shifted, accepted - n_placed);
    $display("results checked %0d, mismatches %0d, long output hold-off %0s",
             checked, mismatches, hold_fired ? "done" : "missed");
    if (mismatches == 0) begin
      $display("two_choice_slot_placement_core regression: pass");
    end else begin
      $display("two_choice_slot_placement_core regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/tcsp_pkg.sv
design/tcsp_slot_mem.sv
design/tcsp_out_reg.sv
design/tcsp_ctrl.sv
design/two_choice_slot_placement_core.sv
sim/tb.sv
